>>> hdl/aae_pkg.sv
package aae_pkg;

  localparam int MAX_SYMBOLS_DEF = 256;
  localparam int FREQ_W          = 17;
  localparam int RANGE_W         = 33;
  localparam int PROD_W          = RANGE_W + FREQ_W;
  localparam int QUO_W           = 33;
  localparam int RUN_W           = 32;
  localparam int RESULT_CAP      = 18;
  localparam int CNT_W           = 5;
  localparam logic [15:0] RESCALE_LIMIT_DEF = 16'd16384;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic REG_SYMBOL_COUNT  = 1'b0;
  localparam logic REG_RESCALE_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDHI,
    S_RDLO,
    S_MULHI,
    S_DIVHI,
    S_MULLO,
    S_DIVLO,
    S_UPD,
    S_RENORM,
    S_FINAL,
    S_SWEEP,
    S_FLUSH
  } state_t;

endpackage

>>> hdl/aae_div.sv
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits (dividend < divisor * 2**QUO_W).
module aae_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [aae_pkg::PROD_W-1:0]  dividend,
  input  logic [aae_pkg::FREQ_W-1:0]  divisor,
  output logic                        done,
  output logic [aae_pkg::QUO_W-1:0]   quotient
);

  localparam int DW = aae_pkg::FREQ_W;
  localparam int QW = aae_pkg::QUO_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [5:0]    step_r, step_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[QW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 6'd0;
      rem_nxt  = dividend[aae_pkg::PROD_W-1:QW];
      quo_nxt  = dividend[QW-1:0];
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DW'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/adaptive_arithmetic_encoder.sv
// Adaptive 32-bit arithmetic encoder with pending (underflow) bits. One item
// is taken at a time while in_tready is high. An encode reads two cumulative
// counts, then runs two 33-step divisions by the total on one shared
// bit-serial divider, then the renormalization shifts, and with adapt an
// update of each table entry from the symbol up to symbol_count (or of the
// whole alphabet when counts are halved). Each result is one determined bit
// plus its follow run. A new result waits in a hold register and moves into
// the output register when the next one is due or when the item ends; the
// coder stalls whenever that move, or a flush result, finds the output
// register still holding an untaken transfer. After reset, after a flush and
// after each symbol_count write the cumulative table is rebuilt by a pass
// over all MAX_SYMBOLS entries during which no item is accepted.
module adaptive_arithmetic_encoder #(
  parameter int MAX_SYMBOLS = aae_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] symbol, [8] adapt
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] out_bit, [32:1] follow_run
  output logic        out_tlast,  // last_of_item
  output logic [0:0]  out_tuser,  // [0] end_of_stream
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int IW = (AW > 8) ? AW : 8;
  localparam int FW = aae_pkg::FREQ_W;
  localparam int QW = aae_pkg::QUO_W;
  localparam int RW = aae_pkg::RUN_W;

  aae_pkg::state_t state_r, state_nxt;

  logic [FW-1:0] cum_mem [MAX_SYMBOLS];
  logic [FW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [FW-1:0] wr_data;
  logic          wr_en;

  logic [31:0]   low_r, low_nxt, high_r, high_nxt, pend_r, pend_nxt;
  logic [FW-1:0] total_r, total_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   limit_r, limit_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic          adapt_r, adapt_nxt;
  logic [FW-1:0] hi_c_r, hi_c_nxt, lo_c_r, lo_c_nxt;
  logic [aae_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [QW-1:0] q_hi_r, q_hi_nxt;
  logic          div_go_r, div_go_nxt, div_done;
  logic [QW-1:0] div_q;
  logic [AW:0]   idx_r, idx_nxt;
  logic          resc_r, resc_nxt, pv_r, pv_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [FW-1:0] acc_r, acc_nxt, prev_r, prev_nxt;
  logic          hold_v_r, hold_v_nxt, hold_bit_r, hold_bit_nxt;
  logic [RW-1:0] hold_run_r, hold_run_nxt;
  logic [aae_pkg::CNT_W-1:0] n_r, n_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          push, push_bit, push_last, push_eos;
  logic [RW-1:0] push_run;
  logic          out_bit_r, out_last_r, out_eos_r;
  logic [RW-1:0] out_run_r;

  logic          out_free, in_accept, issue;
  logic [aae_pkg::RANGE_W-1:0] range;
  logic [FW-1:0] mul_c, half_f, f_val, sum_val;
  logic [IW-1:0] in_sym_ext, sym_ext;
  logic [10:0]   cfg_cnt;
  logic [31:0]   pend_inc;

  assign in_tready  = (state_r == aae_pkg::S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign range      = {1'b0, high_r} - {1'b0, low_r} + 33'd1;
  assign mul_c      = (state_r == aae_pkg::S_MULHI) ? hi_c_r : lo_c_r;
  assign in_sym_ext = IW'(in_tdata[7:0]);
  assign sym_ext    = IW'(sym_r);
  assign pend_inc   = (pend_r == 32'hFFFF_FFFF) ? pend_r : pend_r + 32'd1;
  assign issue      = (idx_r < (AW + 1)'(count_r));
  assign half_f     = (rd_data_r - prev_r) >> 1;
  assign f_val      = (half_f == '0) ? FW'(1) : half_f;
  assign sum_val    = acc_r + f_val;

  aae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (prod_r),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt    = state_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    pend_nxt     = pend_r;
    total_nxt    = total_r;
    count_nxt    = count_r;
    limit_nxt    = limit_r;
    sym_nxt      = sym_r;
    adapt_nxt    = adapt_r;
    hi_c_nxt     = hi_c_r;
    lo_c_nxt     = lo_c_r;
    prod_nxt     = prod_r;
    q_hi_nxt     = q_hi_r;
    div_go_nxt   = 1'b0;
    idx_nxt      = idx_r;
    resc_nxt     = resc_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    acc_nxt      = acc_r;
    prev_nxt     = prev_r;
    hold_v_nxt   = hold_v_r;
    hold_bit_nxt = hold_bit_r;
    hold_run_nxt = hold_run_r;
    n_nxt        = n_r;
    rd_addr      = sym_ext[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = idx_r[AW-1:0];
    wr_data      = FW'(idx_r) + FW'(1);
    push         = 1'b0;
    push_bit     = hold_bit_r;
    push_run     = hold_run_r;
    push_last    = 1'b0;
    push_eos     = 1'b0;
    cfg_cnt      = {2'b00, cfg_wdata[8:0]};

    unique case (state_r)
      aae_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        if (idx_r == (AW + 1)'(MAX_SYMBOLS - 1)) state_nxt = aae_pkg::S_IDLE;
        idx_nxt = idx_r + 1'b1;
      end
      aae_pkg::S_IDLE: begin
        rd_addr = in_sym_ext[AW-1:0];
        if (in_accept) begin
          sym_nxt   = in_tdata[7:0];
          adapt_nxt = in_tdata[8];
          if (in_tuser[0] == aae_pkg::CMD_FLUSH) begin
            state_nxt = aae_pkg::S_FLUSH;
          end else if (11'(in_tdata[7:0]) < 11'(count_r)) begin
            state_nxt = aae_pkg::S_RDHI;
          end
        end
      end
      aae_pkg::S_RDHI: begin
        hi_c_nxt  = rd_data_r;
        rd_addr   = AW'(sym_ext - IW'(1));
        state_nxt = aae_pkg::S_RDLO;
      end
      aae_pkg::S_RDLO: begin
        lo_c_nxt  = (sym_r == 8'd0) ? '0 : rd_data_r;
        state_nxt = aae_pkg::S_MULHI;
      end
      aae_pkg::S_MULHI: begin
        prod_nxt   = range * mul_c;
        div_go_nxt = 1'b1;
        state_nxt  = aae_pkg::S_DIVHI;
      end
      aae_pkg::S_DIVHI: begin
        if (div_done) begin
          q_hi_nxt  = div_q;
          state_nxt = aae_pkg::S_MULLO;
        end
      end
      aae_pkg::S_MULLO: begin
        prod_nxt   = range * mul_c;
        div_go_nxt = 1'b1;
        state_nxt  = aae_pkg::S_DIVLO;
      end
      aae_pkg::S_DIVLO: begin
        if (div_done) begin
          high_nxt  = 32'(low_r + 32'(q_hi_r) - 32'd1);
          low_nxt   = 32'(low_r + 32'(div_q));
          n_nxt     = '0;
          state_nxt = aae_pkg::S_RENORM;
        end
      end
      aae_pkg::S_UPD: begin
        state_nxt = aae_pkg::S_RENORM;
      end
      aae_pkg::S_RENORM: begin
        if (high_r[31] == low_r[31]) begin
          if (!(hold_v_r && !out_free)) begin
            if (n_r < aae_pkg::CNT_W'(aae_pkg::RESULT_CAP)) begin
              push         = hold_v_r;
              hold_v_nxt   = 1'b1;
              hold_bit_nxt = high_r[31];
              hold_run_nxt = pend_r;
              n_nxt        = n_r + 1'b1;
            end
            pend_nxt = '0;
            low_nxt  = {low_r[30:0], 1'b0};
            high_nxt = {high_r[30:0], 1'b1};
          end
        end else if (low_r[30] && !high_r[30]) begin
          pend_nxt = pend_inc;
          low_nxt  = {low_r[30:0], 1'b0} ^ 32'h8000_0000;
          high_nxt = {high_r[30:0], 1'b1} ^ 32'h8000_0000;
        end else begin
          state_nxt = aae_pkg::S_FINAL;
        end
      end
      aae_pkg::S_FINAL: begin
        if (!hold_v_r || out_free) begin
          push       = hold_v_r;
          push_last  = 1'b1;
          hold_v_nxt = 1'b0;
          resc_nxt   = ({1'b0, limit_r} <= total_r);
          idx_nxt    = ({1'b0, limit_r} <= total_r) ? '0 : (AW + 1)'(sym_ext);
          acc_nxt    = '0;
          prev_nxt   = '0;
          state_nxt  = adapt_r ? aae_pkg::S_SWEEP : aae_pkg::S_IDLE;
        end
      end
      aae_pkg::S_SWEEP: begin
        // issue a read each cycle; the write of an entry trails its read, using the registered read data
        rd_addr = idx_r[AW-1:0];
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end
        if (pv_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r;
          if (resc_r) begin
            acc_nxt  = sum_val;
            prev_nxt = rd_data_r;
            wr_data  = sum_val + FW'(IW'(pidx_r) >= sym_ext);
          end else begin
            wr_data = rd_data_r + FW'(1);
          end
        end
        if (!issue && !pv_r) begin
          total_nxt = (resc_r ? acc_r : total_r) + FW'(1);
          state_nxt = aae_pkg::S_IDLE;
        end
      end
      aae_pkg::S_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_bit  = low_r[30];
          push_run  = pend_inc;
          push_last = 1'b1;
          push_eos  = 1'b1;
          low_nxt   = '0;
          high_nxt  = 32'hFFFF_FFFF;
          pend_nxt  = '0;
          total_nxt = FW'(count_r);
          idx_nxt   = '0;
          state_nxt = aae_pkg::S_CLEAR;
        end
      end
      default: state_nxt = aae_pkg::S_CLEAR;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        aae_pkg::REG_SYMBOL_COUNT: begin
          if (cfg_cnt < 11'd2) cfg_cnt = 11'd2;
          if (cfg_cnt > 11'(MAX_SYMBOLS)) cfg_cnt = 11'(MAX_SYMBOLS);
          count_nxt = CW'(cfg_cnt);
          total_nxt = FW'(cfg_cnt);
          idx_nxt   = '0;
          state_nxt = aae_pkg::S_CLEAR;
        end
        aae_pkg::REG_RESCALE_LIMIT: limit_nxt = cfg_wdata;
        default: limit_nxt = limit_r;
      endcase
    end
  end

  assign out_valid_nxt = push ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (wr_en) cum_mem[wr_addr] <= wr_data;
    rd_data_r <= cum_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aae_pkg::S_CLEAR;
      idx_r       <= '0;
      low_r       <= '0;
      high_r      <= 32'hFFFF_FFFF;
      pend_r      <= '0;
      count_r     <= CW'(MAX_SYMBOLS < 256 ? MAX_SYMBOLS : 256);
      total_r     <= FW'(MAX_SYMBOLS < 256 ? MAX_SYMBOLS : 256);
      limit_r     <= aae_pkg::RESCALE_LIMIT_DEF;
      div_go_r    <= 1'b0;
      pv_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      limit_r     <= limit_nxt;
      div_go_r    <= div_go_nxt;
      pv_r        <= pv_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r      <= sym_nxt;
    adapt_r    <= adapt_nxt;
    hi_c_r     <= hi_c_nxt;
    lo_c_r     <= lo_c_nxt;
    prod_r     <= prod_nxt;
    q_hi_r     <= q_hi_nxt;
    resc_r     <= resc_nxt;
    pidx_r     <= pidx_nxt;
    acc_r      <= acc_nxt;
    prev_r     <= prev_nxt;
    hold_bit_r <= hold_bit_nxt;
    hold_run_r <= hold_run_nxt;
    n_r        <= n_nxt;
    if (push) begin
      out_bit_r  <= push_bit;
      out_run_r  <= push_run;
      out_last_r <= push_last;
      out_eos_r  <= push_eos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_run_r, out_bit_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_eos_r;

  a_hold_in_renorm: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (state_r == aae_pkg::S_RENORM || state_r == aae_pkg::S_FINAL))
    else $error("held result outside renormalization");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == aae_pkg::S_DIVHI || state_r == aae_pkg::S_DIVLO))
    else $error("divider finished outside a division state");

  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eos_r) |-> out_last_r)
    else $error("end of stream without last flag");

  a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser[0] == aae_pkg::CMD_FLUSH && !cfg_we)
    |=> state_r == aae_pkg::S_FLUSH)
    else $error("flush not taken");

endmodule

>>> tb/sv/adaptive_arithmetic_encoder_tb.sv
`timescale 1ns / 1ps

module adaptive_arithmetic_encoder_tb;

  typedef struct {
    bit        code_bit;
    bit [31:0] run;
    bit        last;
    bit        eos;
  } code_res_t;

  typedef struct {
    bit       cmd;
    bit [7:0] sym;
    bit       adapt;
    int       n_typed;   // -1: predictor only
    bit       typed_bit;
    bit [31:0] typed_run;
  } dir_row_t;

  localparam int N_DIR = 22;
  localparam int SETTLE = 800;
  localparam bit ENC = aae_pkg::CMD_ENCODE;
  localparam bit FLU = aae_pkg::CMD_FLUSH;
  localparam int NSYM = aae_pkg::MAX_SYMBOLS_DEF;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  adaptive_arithmetic_encoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // coder and model copy
  bit [31:0] lo_q, hi_q, pend_q;
  bit [31:0] freq_q [NSYM];
  bit [31:0] cum_q [NSYM];
  bit [31:0] total_q;
  bit [31:0] alpha_q;
  bit [31:0] limit_q;

  code_res_t code_q[$];
  int n_err, n_items, n_bits, n_flush, n_ignored, n_rescale;

  dir_row_t dir_tab [0:N_DIR-1] = '{
    '{ENC, 8'd0,   1'b0, 8, 1'b0, 32'd0},
    '{ENC, 8'd255, 1'b0, 8, 1'b1, 32'd0},
    '{FLU, 8'd7,   1'b1, 1, 1'b0, 32'd1},
    '{ENC, 8'd128, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd127, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd0,   1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd255, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd255, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd64,  1'b0, -1, 1'b0, 32'd0},
    '{ENC, 8'd191, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd128, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd127, 1'b0, -1, 1'b0, 32'd0},
    '{ENC, 8'd128, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd127, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd85,  1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd170, 1'b1, -1, 1'b0, 32'd0},
    '{FLU, 8'd0,   1'b0, -1, 1'b0, 32'd0},
    '{ENC, 8'd1,   1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd254, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd128, 1'b1, -1, 1'b0, 32'd0},
    '{ENC, 8'd128, 1'b1, -1, 1'b0, 32'd0},
    '{FLU, 8'd255, 1'b1, -1, 1'b0, 32'd0}
  };

  function automatic void model_uniform();
    for (int s = 0; s < NSYM; s++) begin
      freq_q[s] = 1;
      cum_q[s] = s + 1;
    end
    total_q = alpha_q;
  endfunction

  function automatic void coder_clear();
    lo_q = '0;
    hi_q = '1;
    pend_q = '0;
  endfunction

  function automatic void bump_count(bit [7:0] sym);
    bit [31:0] acc, f;
    if (total_q >= limit_q) begin
      acc = 0;
      n_rescale++;
      for (int s = 0; s < alpha_q; s++) begin
        f = freq_q[s] >> 1;
        if (f == 0) f = 1;
        freq_q[s] = f;
        acc += f;
        cum_q[s] = acc;
      end
      total_q = acc;
    end
    freq_q[sym] += 1;
    total_q += 1;
    for (int s = sym; s < alpha_q; s++) cum_q[s] += 1;
  endfunction

  // returns the number of code results the item adds to code_q
  function automatic int code_item(bit cmd, bit [7:0] sym, bit adapt);
    bit [63:0] rng, tot, lo_c, hi_c;
    bit [31:0] nh, nl;
    int n;
    code_res_t r;
    n = 0;
    if (cmd == aae_pkg::CMD_FLUSH) begin
      if (pend_q != '1) pend_q++;
      r = '{lo_q[30], pend_q, 1'b1, 1'b1};
      code_q.push_back(r);
      coder_clear();
      model_uniform();
      return 1;
    end
    if (sym >= alpha_q) return 0;
    rng = {32'd0, hi_q} - {32'd0, lo_q} + 64'd1;
    tot = (total_q == 0) ? 64'd1 : {32'd0, total_q};
    lo_c = (sym == 0) ? 64'd0 : {32'd0, cum_q[sym-1]};
    hi_c = {32'd0, cum_q[sym]};
    nh = 32'(lo_q + (rng * hi_c) / tot - 64'd1);
    nl = 32'(lo_q + (rng * lo_c) / tot);
    hi_q = nh;
    lo_q = nl;
    forever begin
      if (hi_q[31] == lo_q[31]) begin
        if (n < aae_pkg::RESULT_CAP) begin
          r = '{hi_q[31], pend_q, 1'b0, 1'b0};
          code_q.push_back(r);
          n++;
        end
        pend_q = '0;
        lo_q = lo_q << 1;
        hi_q = (hi_q << 1) | 32'd1;
      end else if (lo_q[30] && !hi_q[30]) begin
        if (pend_q != '1) pend_q++;
        lo_q = (lo_q << 1) ^ 32'h8000_0000;
        hi_q = ((hi_q << 1) | 32'd1) ^ 32'h8000_0000;
      end else begin
        break;
      end
    end
    if (adapt) bump_count(sym);
    if (n > 0) code_q[$].last = 1'b1;
    return n;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** adaptive_arithmetic_encoder: FAILED **");
    $finish;
  end

  task automatic write_reg(bit [0:0] idx, bit [15:0] val);
    bit [31:0] v;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == aae_pkg::REG_SYMBOL_COUNT) begin
      v = val & 16'h01FF;
      if (v < 2) v = 2;
      if (v > NSYM) v = NSYM;
      alpha_q = v;
      model_uniform();
    end else begin
      limit_q = val;
    end
    @(posedge clk);
  endtask

  // hold input low and let the coder drain before touching registers
  task automatic drain();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_item(bit cmd, bit [7:0] sym, bit adapt, output int n);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'($urandom), adapt, sym};
    do @(posedge clk); while (!in_tready);
    n = code_item(cmd, sym, adapt);
    n_items++;
    if (cmd == aae_pkg::CMD_FLUSH) n_flush++;
    else if (sym >= alpha_q) n_ignored++;
  endtask

  task automatic random_phase(int n_want);
    int got, n;
    bit cmd, adapt;
    bit [7:0] sym;
    got = 0;
    while (got < n_want) begin
      cmd = ($urandom_range(0, 24) == 0) ? aae_pkg::CMD_FLUSH : aae_pkg::CMD_ENCODE;
      if ($urandom_range(0, 99) < 85) sym = 8'($urandom_range(0, alpha_q - 1));
      else sym = 8'($urandom);
      adapt = ($urandom_range(0, 99) < 80);
      send_item(cmd, sym, adapt, n);
      if (cmd == aae_pkg::CMD_FLUSH || sym < alpha_q) got++;
    end
  endtask

  // result side: random stalls per transfer, compare against oldest prediction
  initial begin
    int w;
    code_res_t e;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      w = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      n_bits++;
      if (code_q.size() == 0) begin
        $error("unexpected result: out_bit %0d follow_run %0d", out_tdata[0], out_tdata[32:1]);
        n_err++;
      end else begin
        e = code_q.pop_front();
        if (out_tdata[0] !== e.code_bit) begin
          $error("out_bit: expected %0d actual %0d", e.code_bit, out_tdata[0]);
          n_err++;
        end
        if (out_tdata[32:1] !== e.run) begin
          $error("follow_run: expected %0d actual %0d", e.run, out_tdata[32:1]);
          n_err++;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_item: expected %0d actual %0d", e.last, out_tlast);
          n_err++;
        end
        if (out_tuser[0] !== e.eos) begin
          $error("end_of_stream: expected %0d actual %0d", e.eos, out_tuser[0]);
          n_err++;
        end
      end
    end
  end

  initial begin
    int n, first, wait_cyc;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    n_err = 0;
    alpha_q = 256;
    limit_q = 32'(aae_pkg::RESCALE_LIMIT_DEF);
    coder_clear();
    model_uniform();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_tab[i].cmd, dir_tab[i].sym, dir_tab[i].adapt, n);
      if (dir_tab[i].n_typed >= 0) begin
        if (n != dir_tab[i].n_typed) begin
          $error("result count row %0d: expected %0d actual %0d", i, dir_tab[i].n_typed, n);
          n_err++;
        end
        // this item's predictions are the newest entries of the queue
        first = code_q.size() - n;
        for (int k = first; k < code_q.size(); k++)
          if (code_q[k].code_bit != dir_tab[i].typed_bit || code_q[k].run != dir_tab[i].typed_run) begin
            $error("typed row %0d: expected bit %0d run %0d", i, dir_tab[i].typed_bit,
                   dir_tab[i].typed_run);
            n_err++;
          end
      end
    end

    // register settings: defaults, extremes, clamped and masked values
    drain();
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'd256);
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'd16384);
    random_phase(30);
    drain();
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'd2);
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'd1024);
    random_phase(40);
    drain();
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'd0);
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'd0);
    random_phase(25);
    drain();
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'd511);
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'd65535);
    random_phase(30);
    drain();
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'hFE11);
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'd1);
    random_phase(30);
    drain();
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'd300);
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'd2000);
    random_phase(30);
    drain();
    write_reg(aae_pkg::REG_RESCALE_LIMIT, 16'($urandom));
    write_reg(aae_pkg::REG_SYMBOL_COUNT, 16'($urandom));
    random_phase(40);

    in_tvalid <= 1'b0;
    wait_cyc = 0;
    while (code_q.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (SETTLE) @(posedge clk);
    if (code_q.size() != 0) begin
      $error("%0d predicted results never arrived", code_q.size());
      n_err++;
    end
    $display("Coded %0d items (%0d flushes, %0d out-of-alphabet) into %0d bit transfers,",
             n_items, n_flush, n_ignored, n_bits);
    $display("across seven register settings with %0d model rescales.", n_rescale);
    if (n_err == 0) begin
      $display("** adaptive_arithmetic_encoder: PASSED **");
    end else begin
      $display("** adaptive_arithmetic_encoder: FAILED **");
    end
    $finish;
  end

endmodule

>>> adaptive_arithmetic_encoder.f
hdl/aae_pkg.sv
hdl/aae_div.sv
hdl/adaptive_arithmetic_encoder.sv
tb/sv/adaptive_arithmetic_encoder_tb.sv
